[rtl/running_median_stream_macros.svh]
// ----------------------------------------------------------------------------
// running_median_stream_macros.svh
// Assertion macros shared by the running median block.
// ----------------------------------------------------------------------------
`ifndef RUNNING_MEDIAN_STREAM_MACROS_SVH
`define RUNNING_MEDIAN_STREAM_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define RMS_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("running_median_stream: same-cycle check failed");

// Next-cycle implication, quiet during reset.
`define RMS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("running_median_stream: next-cycle check failed");

`endif

[rtl/rms_pkg.sv]
// ----------------------------------------------------------------------------
// rms_pkg
// Shared widths, defaults and types of the running median block.
// ----------------------------------------------------------------------------
package rms_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int COUNT_W        = 7;
  localparam int CAPACITY_DEF   = 64;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int OUT_DEPTH_DEF  = 4;

  // operation applied to one sorted cell chain in a cycle
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP_INSERT,
    OP_PUSH
  } chain_op_t;

  typedef struct packed {
    chain_op_t                   op;
    logic                        clear;
    logic signed [SAMPLE_W-1:0]  value;
  } chain_ctl_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0]  sample;
    logic                        restart;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0]  median_value;
    logic [COUNT_W-1:0]          stored_count;
    logic                        dropped;
  } result_t;

endpackage

[rtl/rms_fifo.sv]
// ----------------------------------------------------------------------------
// rms_fifo
// Small first-in first-out queue of register entries.
// ----------------------------------------------------------------------------
module rms_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (level == LW'(DEPTH));
  assign empty   = (level == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

endmodule

[rtl/rms_chain.sv]
// ----------------------------------------------------------------------------
// rms_chain
// Sorted chain of sample cells with parallel compare-and-shift insertion.
// ----------------------------------------------------------------------------
module rms_chain import rms_pkg::*; #(
  parameter int DEPTH   = 32,
  parameter bit DESCEND = 1'b1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  chain_ctl_t                  ctl,
  output logic signed [SAMPLE_W-1:0]  head,
  output logic [$clog2(DEPTH+1)-1:0]  len
);

  localparam int LW = $clog2(DEPTH+1);

  logic signed [SAMPLE_W-1:0] cells      [DEPTH];
  logic signed [SAMPLE_W-1:0] cells_next [DEPTH];
  logic signed [SAMPLE_W-1:0] base       [DEPTH];
  logic signed [SAMPLE_W-1:0] prev       [DEPTH];
  logic [DEPTH-1:0]           ahead;
  logic [DEPTH-1:0]           ahead_prev;
  logic [LW-1:0]              len_next;
  logic [LW-1:0]              eff_len;
  logic [LW-1:0]              base_len;

  assign head = cells[0];

  always_comb begin
    eff_len  = ctl.clear ? '0 : len;
    base_len = (ctl.op == OP_POP_INSERT) ? eff_len - LW'(1) : eff_len;

    // popping the head shifts the chain up by one before insertion
    for (int i = 0; i < DEPTH-1; i++) begin
      base[i] = (ctl.op == OP_POP_INSERT) ? cells[i+1] : cells[i];
    end
    base[DEPTH-1] = cells[DEPTH-1];

    for (int i = 0; i < DEPTH; i++) begin
      ahead[i] = (LW'(i) < base_len) &&
                 (DESCEND ? (base[i] >= ctl.value) : (base[i] <= ctl.value));
    end

    ahead_prev[0] = 1'b1;
    prev[0]       = ctl.value;
    for (int i = 1; i < DEPTH; i++) begin
      ahead_prev[i] = ahead[i-1];
      prev[i]       = base[i-1];
    end

    cells_next = cells;
    len_next   = eff_len;
    case (ctl.op)
      OP_HOLD: begin
        len_next = eff_len;
      end
      OP_INSERT, OP_POP_INSERT: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (ahead[i]) begin
            cells_next[i] = base[i];
          end else if (ahead_prev[i]) begin
            cells_next[i] = ctl.value;
          end else begin
            cells_next[i] = prev[i];
          end
        end
        len_next = (ctl.op == OP_INSERT) ? eff_len + LW'(1) : eff_len;
      end
      OP_PUSH: begin
        cells_next[0] = ctl.value;
        for (int i = 1; i < DEPTH; i++) begin
          cells_next[i] = cells[i-1];
        end
        len_next = eff_len + LW'(1);
      end
      default: begin
        len_next = eff_len;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cells <= cells_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else begin
      len <= len_next;
    end
  end

endmodule

[rtl/rms_back.sv]
// ----------------------------------------------------------------------------
// rms_back
// Execution side: balances two sorted chains and forms the median.
// ----------------------------------------------------------------------------
module rms_back import rms_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  item_t                            in_item,
  output logic                             in_take,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]   out_level,
  output logic                             res_write,
  output result_t                          res
);

  localparam int LD   = (CAPACITY + 1) / 2;
  localparam int UD   = CAPACITY / 2;
  localparam int LWL  = $clog2(LD+1);
  localparam int LWU  = $clog2(UD+1);
  localparam int CW   = $clog2(CAPACITY+1);
  localparam int LVW1 = $clog2(OUT_DEPTH+1) + 1;

  chain_ctl_t                 ctl_lo;
  chain_ctl_t                 ctl_hi;
  logic signed [SAMPLE_W-1:0] head_lo;
  logic signed [SAMPLE_W-1:0] head_hi;
  logic [LWL-1:0]             len_lo;
  logic [LWU-1:0]             len_hi;
  logic [LWL-1:0]             eff_lo;
  logic [LWU-1:0]             eff_hi;
  logic [CW-1:0]              total;
  logic [CW-1:0]              count;
  logic                       at_cap;
  logic                       go_lo;
  logic                       balanced;
  logic                       pend;
  logic                       pend_dropped;
  logic [SAMPLE_W:0]          pair_sum;
  logic [SAMPLE_W:0]          pair_adj;

  // lower half, largest first
  rms_chain #(.DEPTH(LD), .DESCEND(1'b1)) u_lo (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl_lo),
    .head (head_lo),
    .len  (len_lo)
  );

  // upper half, smallest first
  rms_chain #(.DEPTH(UD), .DESCEND(1'b0)) u_hi (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl_hi),
    .head (head_hi),
    .len  (len_hi)
  );

  always_comb begin
    in_take = in_valid &&
              (({1'b0, out_level} + LVW1'(pend)) < LVW1'(OUT_DEPTH));

    eff_lo   = in_item.restart ? '0 : len_lo;
    eff_hi   = in_item.restart ? '0 : len_hi;
    total    = CW'(eff_lo) + CW'(eff_hi);
    at_cap   = (total == CW'(CAPACITY));
    balanced = (CW'(eff_lo) == CW'(eff_hi));
    go_lo    = (eff_lo == '0) || (in_item.sample <= head_lo);

    ctl_lo.op    = OP_HOLD;
    ctl_lo.clear = in_take && in_item.restart;
    ctl_lo.value = in_item.sample;
    ctl_hi.op    = OP_HOLD;
    ctl_hi.clear = in_take && in_item.restart;
    ctl_hi.value = in_item.sample;

    if (in_take && !at_cap) begin
      if (go_lo && balanced) begin
        ctl_lo.op = OP_INSERT;
      end else if (go_lo) begin
        // lower half would grow two ahead: its top moves up
        ctl_lo.op    = OP_POP_INSERT;
        ctl_hi.op    = OP_PUSH;
        ctl_hi.value = head_lo;
      end else if (!balanced) begin
        ctl_hi.op = OP_INSERT;
      end else if ((eff_hi == '0) || (in_item.sample <= head_hi)) begin
        ctl_lo.op = OP_PUSH;
      end else begin
        ctl_lo.op    = OP_PUSH;
        ctl_lo.value = head_hi;
        ctl_hi.op    = OP_POP_INSERT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    pend_dropped <= at_cap;
  end

  // median stage reads the chain heads after the update has landed
  always_comb begin
    count     = CW'(len_lo) + CW'(len_hi);
    pair_sum  = {head_lo[SAMPLE_W-1], head_lo} + {head_hi[SAMPLE_W-1], head_hi};
    pair_adj  = pair_sum + {{SAMPLE_W{1'b0}}, pair_sum[SAMPLE_W]};
    res_write = pend;
    res.median_value = count[0] ? head_lo : pair_adj[SAMPLE_W:1];
    res.stored_count = COUNT_W'(count);
    res.dropped      = pend_dropped;
  end

endmodule

[rtl/running_median_stream.sv]
// ----------------------------------------------------------------------------
// running_median_stream
// Running median of a stream of signed 16-bit samples.
//
// Each item pushed in carries a sample and a restart flag; each yields one
// result item: the median of every sample held since the last restart, the
// number held, and a flag when the store was full and the sample was thrown
// away (the median then stays that of the unchanged store). An even count
// gives the mean of the two middle samples, truncated toward zero. Samples
// are kept in two sorted cell chains, the lower half largest first and the
// upper half smallest first, kept within one entry of each other in length,
// so the median always comes from the two chain heads. The block sustains
// one item per clock while results are taken: the whole chain compares and
// shifts together. An item goes intake queue -> chain update -> median
// stage -> result queue: the chains update as it leaves the intake, the
// median stage registers that it is in flight, and its result is then
// written into the result queue. Results wait in a queue of OUT_DEPTH
// entries; once that queue together with the item in the median stage
// would fill it, the chains stop taking items, the intake backs up in its
// queue of QUEUE_DEPTH entries and full rises. No clearing pass is needed
// after reset.
// ----------------------------------------------------------------------------
`include "running_median_stream_macros.svh"

module running_median_stream import rms_pkg::*; #(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int OUT_DEPTH   = OUT_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // intake side
  input  logic                        push,
  output logic                        full,
  input  logic signed [SAMPLE_W-1:0]  sample,
  input  logic                        restart,
  // result side
  output logic                        empty,
  input  logic                        pop,
  output logic signed [SAMPLE_W-1:0]  median_value,
  output logic [COUNT_W-1:0]          stored_count,
  output logic                        dropped
);

  item_t                          in_item;
  item_t                          q_item;
  logic [$bits(item_t)-1:0]       q_dout;
  logic                           q_empty;
  logic                           q_pop;
  logic [$clog2(OUT_DEPTH+1)-1:0] out_level;
  logic                           out_full;
  logic                           res_write;
  result_t                        res;
  result_t                        out_res;
  logic [$bits(result_t)-1:0]     out_dout;

  assign in_item.sample  = sample;
  assign in_item.restart = restart;
  assign q_item          = item_t'(q_dout);

  // intake queue: takes items whenever it has room
  rms_fifo #(.WIDTH($bits(item_t)), .DEPTH(QUEUE_DEPTH)) u_intake (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (in_item),
    .full  (full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty),
    .level ()
  );

  // chain update and median stages
  rms_back #(.CAPACITY(CAPACITY), .OUT_DEPTH(OUT_DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (!q_empty),
    .in_item   (q_item),
    .in_take   (q_pop),
    .out_level (out_level),
    .res_write (res_write),
    .res       (res)
  );

  // result queue: space for the in-flight item is reserved before issue
  rms_fifo #(.WIDTH($bits(result_t)), .DEPTH(OUT_DEPTH)) u_results (
    .clk   (clk),
    .rst   (rst),
    .push  (res_write),
    .din   (res),
    .full  (out_full),
    .pop   (pop),
    .dout  (out_dout),
    .empty (empty),
    .level (out_level)
  );

  assign out_res      = result_t'(out_dout);
  assign median_value = out_res.median_value;
  assign stored_count = out_res.stored_count;
  assign dropped      = out_res.dropped;

  // a result never meets a full result queue
  `RMS_ASSERT_IMPL(a_no_result_loss, res_write, !out_full)
  // every item taken from the intake lands a result in the next cycle
  `RMS_ASSERT_NEXT(a_issue_gives_result, q_pop, res_write)
  // a dropped sample is reported only with the store at capacity
  `RMS_ASSERT_IMPL(a_drop_at_capacity, !empty && dropped, stored_count == COUNT_W'(CAPACITY))

endmodule
